// File: sv/ubd_pkg.sv
// shared types, constants and result builders for the unaligned block deblocker
package ubd_pkg;

    localparam int OFFSET_BITS = 48;
    localparam int COUNT_BITS  = 32;
    localparam int BS_W        = 17;
    localparam int SOFF_W      = 16;
    localparam int PADDR_W     = 3;
    localparam int REM_CNT_W   = $clog2(OFFSET_BITS + 1);

    localparam logic [BS_W-1:0] BS_RESET = BS_W'(512);
    localparam logic [BS_W-1:0] BS_MAX   = BS_W'(65536);

    typedef enum logic [1:0] {
        K_ISSUE      = 2'd0,
        K_TO_CLIENT  = 2'd1,
        K_TO_SCRATCH = 2'd2,
        K_DONE       = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ERR   = 2'd1,
        ST_SHORT = 2'd2,
        ST_BUSY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BSEL_SCRATCH = 2'd0,
        BSEL_MID     = 2'd1,
        BSEL_WHOLE   = 2'd2
    } t_bsel;

    typedef enum logic {
        CMD_REQUEST    = 1'b0,
        CMD_COMPLETION = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                   command;
        logic [OFFSET_BITS-1:0] byte_start;
        logic [COUNT_BITS-1:0]  byte_count;
        logic                   is_write;
        logic                   sub_error;
        logic [COUNT_BITS-1:0]  actual_count;
    } t_in_item;

    typedef struct packed {
        t_kind                  kind;
        logic [OFFSET_BITS-1:0] media_offset;
        logic [COUNT_BITS-1:0]  length;
        logic                   write_dir;
        t_bsel                  buffer_select;
        logic [COUNT_BITS-1:0]  client_offset;
        logic [SOFF_W-1:0]      scratch_offset;
        t_status                status;
        logic [COUNT_BITS-1:0]  bytes_done;
        logic                   last;
    } t_out_item;

    // remainder unit handshake
    typedef struct packed {
        logic                   start;
        logic [OFFSET_BITS-1:0] dividend;
        logic [BS_W-1:0]        divisor;
    } t_rem_req;

    function automatic t_out_item mk_issue(logic [OFFSET_BITS-1:0] media,
                                           logic [COUNT_BITS-1:0] len, logic wdir,
                                           t_bsel bsel, logic [COUNT_BITS-1:0] coff);
        t_out_item r;
        r = '0;
        r.kind          = K_ISSUE;
        r.media_offset  = media;
        r.length        = len;
        r.write_dir     = wdir;
        r.buffer_select = bsel;
        r.client_offset = coff;
        return r;
    endfunction

    function automatic t_out_item mk_copy(t_kind kind, logic [COUNT_BITS-1:0] len,
                                          logic [COUNT_BITS-1:0] coff,
                                          logic [SOFF_W-1:0] soff);
        t_out_item r;
        r = '0;
        r.kind           = kind;
        r.length         = len;
        r.client_offset  = coff;
        r.scratch_offset = soff;
        return r;
    endfunction

    function automatic t_out_item mk_done(t_status st, logic [COUNT_BITS-1:0] done);
        t_out_item r;
        r = '0;
        r.kind       = K_DONE;
        r.status     = st;
        r.bytes_done = done;
        return r;
    endfunction

    // same beat marked as the final one
    function automatic t_out_item with_last(t_out_item b);
        t_out_item r;
        r      = b;
        r.last = 1'b1;
        return r;
    endfunction

    // saturating byte counter add
    function automatic logic [COUNT_BITS-1:0] sat_add(logic [COUNT_BITS-1:0] a,
                                                      logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

endpackage

// File: sv/ubd_cfg.sv
// block size register with its apb-style port and the clamped size in force
module ubd_cfg
    import ubd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [BS_W-1:0]    o_block_size
);

    logic [BS_W-1:0] r_bs;

    // register write on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs <= BS_RESET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_bs <= pwdata[BS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32-BS_W){1'b0}}, r_bs} : 32'd0;

    // zero acts as one, oversize acts as the maximum
    always_comb begin
        if (r_bs == '0) begin
            o_block_size = BS_W'(1);
        end else if (r_bs > BS_MAX) begin
            o_block_size = BS_MAX;
        end else begin
            o_block_size = r_bs;
        end
    end

endmodule

// File: sv/ubd_rem.sv
// bit-serial remainder unit, one dividend bit per cycle
module ubd_rem
    import ubd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_rem_req        i_req,
    output logic            o_done,
    output logic [BS_W-1:0] o_rem
);

    logic [OFFSET_BITS-1:0] r_div;
    logic [BS_W-1:0]        r_d;
    logic [BS_W-1:0]        r_rem;
    logic [REM_CNT_W-1:0]   r_cnt;
    logic                   r_run;
    logic [BS_W:0]          n_trial;
    logic [BS_W-1:0]        n_rem;

    // shift in next dividend bit, subtract divisor when it fits
    always_comb begin
        n_trial = {r_rem, r_div[OFFSET_BITS-1]};
        if (n_trial >= {1'b0, r_d}) begin
            n_rem = BS_W'(n_trial - {1'b0, r_d});
        end else begin
            n_rem = n_trial[BS_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_run <= 1'b1;
            r_cnt <= REM_CNT_W'(OFFSET_BITS);
        end else if (r_run && r_cnt != '0) begin
            r_cnt <= r_cnt - REM_CNT_W'(1);
        end else begin
            r_run <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.dividend;
            r_d   <= i_req.divisor;
            r_rem <= '0;
        end else if (r_run && r_cnt != '0) begin
            r_div <= {r_div[OFFSET_BITS-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_run && (r_cnt == '0);
    assign o_rem  = r_rem;

endmodule

// File: sv/unaligned_block_deblocker.sv
// Unaligned block deblocker: splits byte requests into block-aligned sub-requests.
// Input channel (i_in_valid/o_in_ready) carries client requests and completions of
// the sub-request issued before; the output channel (o_out_valid/i_out_ready)
// carries up to two result beats per input: issues, copies and a done beat,
// the final one marked by last.
// The block works on one input beat at a time and is not ready until every
// result beat of that input has been taken; it is ready again right after that.
// A new request runs the shared bit-serial remainder unit twice (start offset,
// then length); an aligned request then shows its beat, while a split one
// first passes the split states S_SPLIT_A to S_SPLIT_D and the step state S_STEP.
// Completions pass through S_STEP before their first result beat; busy answers
// go straight to S_OUT. Results wait in a two-entry result register; a stalled
// receiver just holds the current beat and the block takes no new input meanwhile.
// Synchronous active-low reset returns the block to idle, block size 512.
// The user must write the block size register through the apb-style port only
// while no input is pending; the block itself does not enforce this.
module unaligned_block_deblocker
    import ubd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_REM_A   = 10'b0000000010,
        S_REM_B   = 10'b0000000100,
        S_SPLIT_A = 10'b0000001000,
        S_SPLIT_B = 10'b0000010000,
        S_SPLIT_C = 10'b0000100000,
        S_SPLIT_D = 10'b0001000000,
        S_STEP    = 10'b0010000000,
        S_OUT     = 10'b0100000000,
        S_SPARE   = 10'b1000000000
    } t_seq;

    typedef enum logic [8:0] {
        PH_IDLE   = 9'b000000001,
        PH_RHEAD  = 9'b000000010,
        PH_RMID   = 9'b000000100,
        PH_RTAIL  = 9'b000001000,
        PH_WHEADR = 9'b000010000,
        PH_WHEADW = 9'b000100000,
        PH_WMID   = 9'b001000000,
        PH_WTAILR = 9'b010000000,
        PH_WTAILW = 9'b100000000
    } t_phase;

    logic [BS_W-1:0]        w_bs;
    t_rem_req               w_rem_req;
    logic                   w_rem_done;
    logic [BS_W-1:0]        w_rem;

    t_seq                   r_seq;
    t_phase                 r_phase;
    t_in_item               r_in;
    logic                   r_mode_go;
    logic [SOFF_W-1:0]      r_off;
    logic [SOFF_W-1:0]      r_crem;
    logic                   r_small;
    logic [COUNT_BITS-1:0]  r_head;
    logic [COUNT_BITS-1:0]  r_mid;
    logic [COUNT_BITS-1:0]  r_tail;
    logic [COUNT_BITS-1:0]  r_xfer;
    logic [COUNT_BITS-1:0]  r_cur;
    logic                   r_wr;
    logic [OFFSET_BITS-1:0] r_addr_head;
    logic [OFFSET_BITS-1:0] r_addr_mid;
    logic [OFFSET_BITS-1:0] r_addr_tail;
    t_out_item              r_res [2];
    logic                   r_nres;
    logic                   r_idx;

    // step results
    t_out_item              n_res [2];
    logic [1:0]             n_k;
    t_phase                 n_phase;
    logic [COUNT_BITS-1:0]  n_cur;
    logic [COUNT_BITS-1:0]  n_xfer;

    // split helpers
    logic [COUNT_BITS:0]    w_span;
    logic [BS_W-1:0]        w_tsum;

    ubd_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_block_size (w_bs)
    );

    ubd_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rem_req),
        .o_done  (w_rem_done),
        .o_rem   (w_rem)
    );

    assign o_in_ready  = (r_seq == S_IDLE);
    assign o_out_valid = (r_seq == S_OUT);
    assign o_out_item  = r_res[r_idx];

    // remainder unit launch: start offset on accept, then length
    always_comb begin
        w_rem_req.start    = 1'b0;
        w_rem_req.dividend = r_in.byte_start;
        w_rem_req.divisor  = w_bs;
        if (r_seq == S_REM_A && w_rem_done) begin
            w_rem_req.start    = 1'b1;
            w_rem_req.dividend = {{(OFFSET_BITS-COUNT_BITS){1'b0}}, r_in.byte_count};
        end else if (r_seq == S_IDLE && i_in_valid && i_in_item.command == CMD_REQUEST
                     && r_phase == PH_IDLE) begin
            w_rem_req.start    = 1'b1;
            w_rem_req.dividend = i_in_item.byte_start;
        end
    end

    // split arithmetic
    assign w_span = {1'b0, r_in.byte_count} + {{(COUNT_BITS+1-SOFF_W){1'b0}}, r_off};
    assign w_tsum = {1'b0, r_off} + {1'b0, r_crem};

    // one phase step: completion handling and entry into the next part
    always_comb begin
        logic                  v_go;
        logic                  v_fin;
        logic                  v_ign;
        logic [1:0]            v_from;
        t_status               v_st;
        logic [COUNT_BITS-1:0] v_c;
        logic [COUNT_BITS-1:0] v_off32;
        logic [COUNT_BITS-1:0] v_bs32;
        logic [COUNT_BITS-1:0] v_act;

        n_res[0] = '0;
        n_res[1] = '0;
        n_k      = 2'd0;
        n_phase  = r_phase;
        n_cur    = r_cur;
        n_xfer   = r_xfer;
        v_go     = 1'b0;
        v_fin    = 1'b0;
        v_ign    = 1'b0;
        v_from   = 2'd0;
        v_st     = ST_OK;
        v_c      = '0;
        v_act    = r_in.actual_count;
        v_off32  = {{(COUNT_BITS-SOFF_W){1'b0}}, r_off};
        v_bs32   = {{(COUNT_BITS-BS_W){1'b0}}, w_bs};

        if (r_mode_go) begin
            v_go = 1'b1;
        end else begin
            if (r_in.sub_error) begin
                v_st = ST_ERR;
            end
            // account for the completed sub-request
            unique case (r_phase)
                PH_RHEAD: begin
                    if (v_act > v_off32) begin
                        v_c = v_act - v_off32;
                        if (v_c > r_head) begin
                            v_c = r_head;
                        end
                        n_res[n_k[0]] = mk_copy(K_TO_CLIENT, v_c, n_xfer, r_off);
                        n_k = n_k + 2'd1;
                        n_xfer = sat_add(n_xfer, v_c);
                        if (v_c < r_head && !r_in.sub_error) begin
                            v_st = ST_SHORT;
                        end
                    end
                end
                PH_RMID, PH_WMID: begin
                    n_xfer = sat_add(n_xfer, v_act);
                end
                PH_RTAIL: begin
                    v_c = (v_act < r_tail) ? v_act : r_tail;
                    if (v_c != '0) begin
                        n_res[n_k[0]] = mk_copy(K_TO_CLIENT, v_c, n_xfer, '0);
                        n_k = n_k + 2'd1;
                        n_xfer = sat_add(n_xfer, v_c);
                        if (v_c < r_tail && !r_in.sub_error) begin
                            v_st = ST_SHORT;
                        end
                    end
                end
                PH_WHEADR: begin
                    if (v_act == r_cur) begin
                        n_res[n_k[0]] = mk_copy(K_TO_SCRATCH, r_head, n_xfer, r_off);
                        n_k = n_k + 2'd1;
                    end
                end
                PH_WHEADW: begin
                    if (v_act == r_cur) begin
                        n_xfer = sat_add(n_xfer, r_head);
                    end
                end
                PH_WTAILR: begin
                    if (v_act == r_cur) begin
                        n_res[n_k[0]] = mk_copy(K_TO_SCRATCH, r_tail, n_xfer, '0);
                        n_k = n_k + 2'd1;
                    end
                end
                PH_WTAILW: begin
                    if (v_act == r_cur) begin
                        n_xfer = sat_add(n_xfer, r_tail);
                    end
                end
                default: begin
                    v_ign = 1'b1;
                end
            endcase

            // decide how to continue
            if (!v_ign) begin
                if (v_st != ST_OK || v_act != r_cur) begin
                    v_fin = 1'b1;
                end else begin
                    unique case (r_phase)
                        PH_WHEADR: begin
                            n_phase = PH_WHEADW;
                            n_cur   = v_bs32;
                            n_res[n_k[0]] = mk_issue(r_addr_head, v_bs32, 1'b1,
                                                     BSEL_SCRATCH, '0);
                            n_k = n_k + 2'd1;
                        end
                        PH_WTAILR: begin
                            n_phase = PH_WTAILW;
                            n_cur   = v_bs32;
                            n_res[n_k[0]] = mk_issue(r_addr_tail, v_bs32, 1'b1,
                                                     BSEL_SCRATCH, '0);
                            n_k = n_k + 2'd1;
                        end
                        PH_RHEAD, PH_WHEADW: begin
                            v_go   = 1'b1;
                            v_from = 2'd1;
                        end
                        PH_RMID, PH_WMID: begin
                            v_go   = 1'b1;
                            v_from = 2'd2;
                        end
                        default: begin
                            v_go   = 1'b1;
                            v_from = 2'd3;
                        end
                    endcase
                end
            end
        end

        // enter the next non-empty part
        if (v_go) begin
            if (v_from == 2'd0 && r_head != '0) begin
                n_phase = r_wr ? PH_WHEADR : PH_RHEAD;
                n_cur   = v_bs32;
                n_res[n_k[0]] = mk_issue(r_addr_head, v_bs32, 1'b0, BSEL_SCRATCH, '0);
                n_k = n_k + 2'd1;
            end else if (v_from < 2'd2 && r_mid != '0) begin
                n_phase = r_wr ? PH_WMID : PH_RMID;
                n_cur   = r_mid;
                n_res[n_k[0]] = mk_issue(r_addr_mid, r_mid, r_wr, BSEL_MID, r_head);
                n_k = n_k + 2'd1;
            end else if (v_from < 2'd3 && r_tail != '0) begin
                n_phase = r_wr ? PH_WTAILR : PH_RTAIL;
                n_cur   = v_bs32;
                n_res[n_k[0]] = mk_issue(r_addr_tail, v_bs32, 1'b0, BSEL_SCRATCH, '0);
                n_k = n_k + 2'd1;
            end else begin
                v_fin = 1'b1;
            end
        end

        // request done beat
        if (v_fin) begin
            n_phase = PH_IDLE;
            n_res[n_k[0]] = mk_done(v_st, n_xfer);
            n_k = n_k + 2'd1;
        end

        if (n_k == 2'd1) begin
            n_res[0].last = 1'b1;
        end else if (n_k == 2'd2) begin
            n_res[1].last = 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= S_IDLE;
            r_phase <= PH_IDLE;
            r_idx   <= 1'b0;
            r_nres  <= 1'b0;
        end else begin
            unique case (r_seq)
                S_IDLE: begin
                    r_idx <= 1'b0;
                    if (i_in_valid) begin
                        if (i_in_item.command == CMD_COMPLETION) begin
                            r_seq <= S_STEP;
                        end else if (r_phase != PH_IDLE) begin
                            r_nres <= 1'b0;
                            r_seq  <= S_OUT;
                        end else begin
                            r_seq <= S_REM_A;
                        end
                    end
                end
                S_REM_A: begin
                    if (w_rem_done) begin
                        r_seq <= S_REM_B;
                    end
                end
                S_REM_B: begin
                    if (w_rem_done) begin
                        if (r_off == '0 && w_rem == '0) begin
                            r_nres <= 1'b0;
                            r_seq  <= S_OUT;
                        end else begin
                            r_seq <= S_SPLIT_A;
                        end
                    end
                end
                S_SPLIT_A: r_seq <= S_SPLIT_B;
                S_SPLIT_B: r_seq <= S_SPLIT_C;
                S_SPLIT_C: r_seq <= S_SPLIT_D;
                S_SPLIT_D: r_seq <= S_STEP;
                S_STEP: begin
                    r_phase <= n_phase;
                    r_nres  <= (n_k == 2'd2);
                    r_seq   <= (n_k == 2'd0) ? S_IDLE : S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        if (r_idx == r_nres) begin
                            r_seq <= S_IDLE;
                        end else begin
                            r_idx <= 1'b1;
                        end
                    end
                end
                default: r_seq <= S_IDLE;
            endcase
        end
    end

    // request bookkeeping and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xfer <= '0;
            r_cur  <= '0;
        end else begin
            case (r_seq)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in      <= i_in_item;
                        r_mode_go <= (i_in_item.command == CMD_REQUEST);
                        if (i_in_item.command == CMD_REQUEST && r_phase != PH_IDLE) begin
                            r_res[0] <= with_last(mk_done(ST_BUSY, '0));
                        end
                    end
                end
                S_REM_A: begin
                    if (w_rem_done) begin
                        r_off <= w_rem[SOFF_W-1:0];
                    end
                end
                S_REM_B: begin
                    if (w_rem_done) begin
                        r_crem   <= w_rem[SOFF_W-1:0];
                        r_res[0] <= with_last(mk_issue(r_in.byte_start, r_in.byte_count,
                                                       r_in.is_write, BSEL_WHOLE, '0));
                    end
                end
                S_SPLIT_A: begin
                    r_small     <= (w_span < {{(COUNT_BITS+1-BS_W){1'b0}}, w_bs});
                    r_wr        <= r_in.is_write;
                    r_xfer      <= '0;
                    r_cur       <= '0;
                    r_addr_head <= r_in.byte_start
                                   - {{(OFFSET_BITS-SOFF_W){1'b0}}, r_off};
                    if (w_tsum >= w_bs) begin
                        r_tail <= {{(COUNT_BITS-BS_W){1'b0}}, BS_W'(w_tsum - w_bs)};
                    end else begin
                        r_tail <= {{(COUNT_BITS-BS_W){1'b0}}, w_tsum};
                    end
                    if (r_off != '0) begin
                        r_head <= {{(COUNT_BITS-BS_W){1'b0}}, BS_W'(w_bs - {1'b0, r_off})};
                    end else begin
                        r_head <= '0;
                    end
                end
                S_SPLIT_B: begin
                    if (r_small) begin
                        r_head <= r_in.byte_count;
                        r_tail <= '0;
                        r_mid  <= '0;
                    end else begin
                        r_mid <= r_in.byte_count - r_head;
                    end
                end
                S_SPLIT_C: begin
                    r_mid      <= r_mid - r_tail;
                    r_addr_mid <= r_in.byte_start
                                  + {{(OFFSET_BITS-COUNT_BITS){1'b0}}, r_head};
                end
                S_SPLIT_D: begin
                    r_addr_tail <= r_addr_mid + {{(OFFSET_BITS-COUNT_BITS){1'b0}}, r_mid};
                end
                S_STEP: begin
                    r_res[0] <= n_res[0];
                    r_res[1] <= n_res[1];
                    r_cur    <= n_cur;
                    r_xfer   <= n_xfer;
                end
                default: begin
                end
            endcase
        end
    end

endmodule
